// ===== rtl/char_lcd_parallel_controller_defines.svh =====
// Assertion helpers for the character LCD controller checkers.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef CHAR_LCD_PARALLEL_CONTROLLER_DEFINES_SVH
`define CHAR_LCD_PARALLEL_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define CLCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clcd check failed");

// Next-cycle implication.
`define CLCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clcd check failed");

`endif

// ===== rtl/clcd_pkg.sv =====
package clcd_pkg;

    localparam int MAX_ROWS    = 4;
    localparam int CGRAM_SLOTS = 8;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    // request codes
    localparam logic [3:0] FN_INIT    = 4'd0;
    localparam logic [3:0] FN_DATA    = 4'd1;
    localparam logic [3:0] FN_COMMAND = 4'd2;
    localparam logic [3:0] FN_CLEAR   = 4'd3;
    localparam logic [3:0] FN_HOME    = 4'd4;
    localparam logic [3:0] FN_CURSOR  = 4'd5;
    localparam logic [3:0] FN_CGRAM   = 4'd6;
    localparam logic [3:0] FN_CONTROL = 4'd7;
    localparam logic [3:0] FN_ENTRY   = 4'd8;
    localparam logic [3:0] FN_SHIFT   = 4'd9;

    // register indexes
    localparam logic [1:0] REG_WIDE_BUS    = 2'd0;
    localparam logic [1:0] REG_COLUMNS     = 2'd1;
    localparam logic [1:0] REG_ROWS_IN_USE = 2'd2;
    localparam logic [1:0] REG_TALL_FONT   = 2'd3;

    // settle time codes
    localparam logic [1:0] SET_100  = 2'd0;
    localparam logic [1:0] SET_250  = 2'd1;
    localparam logic [1:0] SET_4600 = 2'd2;
    localparam logic [1:0] SET_2100 = 2'd3;

    localparam logic [15:0] LEAD_POWER_ON = 16'd50000;

    // display command bytes
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] CMD_ENTRY    = 8'h04;
    localparam logic [7:0] CMD_CONTROL  = 8'h08;
    localparam logic [7:0] CMD_SHIFT    = 8'h18;
    localparam logic [7:0] CMD_FUNCTION = 8'h20;
    localparam logic [7:0] CMD_CGRAM    = 8'h40;
    localparam logic [7:0] CMD_DDRAM    = 8'h80;
    localparam logic [6:0] ROW1_OFFSET  = 7'h40;

    typedef struct packed {
        logic [3:0] func;
        logic [7:0] value;
        logic [6:0] col;
        logic [1:0] row;
    } in_t;

    typedef struct packed {
        logic        rs;
        logic [7:0]  bus_value;
        logic [15:0] lead_us;
        logic [12:0] settle_us;
        logic        last;
    } out_t;

    typedef struct packed {
        logic       wide_bus;
        logic [5:0] columns;
        logic [2:0] rows_in_use;
        logic       tall_font;
    } cfg_t;

    // one byte (split) or one raw strobe
    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic       lead;
        logic [1:0] settle;
        logic       split;
        logic       last;
    } op_t;

    function automatic logic [12:0] settle_value(input logic [1:0] code);
        logic [12:0] v;
        case (code)
            SET_100:  v = 13'd100;
            SET_250:  v = 13'd250;
            SET_4600: v = 13'd4600;
            SET_2100: v = 13'd2100;
            default:  v = 13'd100;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/clcd_fifo.sv =====
module clcd_fifo
    import clcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  op_t  wr_op,
    output logic full,
    input  logic rd_en,
    output op_t  rd_op,
    output logic empty
);

    op_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign rd_op = mem_reg[rd_ptr_reg];
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

// ===== rtl/clcd_front.sv =====
module clcd_front
    import clcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic push,
    input  in_t  request,
    output logic full,
    input  logic fifo_full,
    output logic op_valid,
    output op_t  op
);

    logic       init_busy_reg, init_busy_next;
    logic [2:0] init_t_reg, init_t_next;
    logic [2:0] ctrl_reg, ctrl_next;
    logic [1:0] entry_reg, entry_next;

    logic       accept;
    logic [7:0] fn_byte;
    logic [2:0] row_lim, row_c;
    logic [6:0] row_off, addr;
    logic [2:0] loc;
    logic [2:0] ctrl_upd;
    logic [1:0] entry_upd;
    op_t        req_op;
    logic       req_known;

    localparam logic [2:0] MAX_ROW_IDX = 3'(MAX_ROWS - 1);
    localparam logic [2:0] CG_MAX      = 3'(CGRAM_SLOTS - 1);
    localparam logic [2:0] INIT_LAST   = 3'd7;

    // one step of the power-on list; the wide bus skips step 3
    function automatic op_t init_op(input logic [2:0] t, input logic wide,
                                    input logic [7:0] fnb);
        op_t o;
        o.rs     = 1'b0;
        o.data   = 8'h03;
        o.lead   = 1'b0;
        o.settle = SET_100;
        o.split  = 1'b0;
        o.last   = 1'b0;
        case (t)
            3'd0:
            begin
                o.data   = wide ? fnb : 8'h03;
                o.lead   = 1'b1;
                o.settle = SET_4600;
            end
            3'd1:
            begin
                o.data   = wide ? fnb : 8'h03;
                o.settle = wide ? SET_250 : SET_4600;
            end
            3'd2:
            begin
                o.data   = wide ? fnb : 8'h03;
                o.settle = wide ? SET_100 : SET_250;
            end
            3'd3:
            begin
                o.data = 8'h02;
            end
            3'd4:
            begin
                o.data  = fnb;
                o.split = !wide;
            end
            3'd5:
            begin
                o.data  = CMD_CONTROL | 8'h04;
                o.split = !wide;
            end
            3'd6:
            begin
                o.data   = CMD_CLEAR;
                o.settle = SET_2100;
                o.split  = !wide;
            end
            3'd7:
            begin
                o.data  = CMD_ENTRY | 8'h02;
                o.split = !wide;
                o.last  = 1'b1;
            end
            default:
            begin
                o.data = 8'h03;
            end
        endcase
        return o;
    endfunction

    assign full   = init_busy_reg || fifo_full;
    assign accept = push && !full;

    assign fn_byte = CMD_FUNCTION
                   | {3'b000, cfg.wide_bus, (cfg.rows_in_use > 3'd1),
                      (cfg.tall_font && cfg.rows_in_use == 3'd1), 2'b00};

    // cursor row clamp and address
    always_comb
    begin
        row_lim = (cfg.rows_in_use == 3'd0) ? 3'd1 : cfg.rows_in_use;
        row_c   = {1'b0, request.row};
        if (row_c > MAX_ROW_IDX)
        begin
            row_c = MAX_ROW_IDX;
        end
        if (row_c >= row_lim)
        begin
            row_c = row_lim - 3'd1;
        end
        case (row_c[1:0])
            2'd0:    row_off = 7'h00;
            2'd1:    row_off = ROW1_OFFSET;
            2'd2:    row_off = {1'b0, cfg.columns};
            default: row_off = ROW1_OFFSET + {1'b0, cfg.columns};
        endcase
        addr = request.col + row_off;
        loc  = (request.value > {5'b0, CG_MAX}) ? CG_MAX : request.value[2:0];
    end

    assign ctrl_upd  = request.value[7] ? (ctrl_reg | request.value[2:0])
                                        : (ctrl_reg & ~request.value[2:0]);
    assign entry_upd = request.value[7] ? (entry_reg | request.value[1:0])
                                        : (entry_reg & ~request.value[1:0]);

    always_comb
    begin
        req_op.rs     = 1'b0;
        req_op.data   = request.value;
        req_op.lead   = 1'b0;
        req_op.settle = SET_100;
        req_op.split  = !cfg.wide_bus;
        req_op.last   = 1'b1;
        req_known     = 1'b1;
        case (request.func)
            FN_DATA:    req_op.rs = 1'b1;
            FN_COMMAND: req_op.data = request.value;
            FN_CLEAR:
            begin
                req_op.data   = CMD_CLEAR;
                req_op.settle = SET_2100;
            end
            FN_HOME:
            begin
                req_op.data   = CMD_HOME;
                req_op.settle = SET_2100;
            end
            FN_CURSOR:  req_op.data = CMD_DDRAM | {1'b0, addr};
            FN_CGRAM:   req_op.data = CMD_CGRAM | {2'b00, loc, 3'b000};
            FN_CONTROL: req_op.data = CMD_CONTROL | {5'b0, ctrl_upd};
            FN_ENTRY:   req_op.data = CMD_ENTRY | {6'b0, entry_upd};
            FN_SHIFT:   req_op.data = CMD_SHIFT | {5'b0, request.value[0], 2'b00};
            FN_INIT:    req_op = init_op(3'd0, cfg.wide_bus, fn_byte);
            default:    req_known = 1'b0;
        endcase
    end

    always_comb
    begin
        init_busy_next = init_busy_reg;
        init_t_next    = init_t_reg;
        ctrl_next      = ctrl_reg;
        entry_next     = entry_reg;
        op_valid       = 1'b0;
        op             = req_op;
        if (init_busy_reg)
        begin
            op = init_op(init_t_reg, cfg.wide_bus, fn_byte);
            if (!fifo_full)
            begin
                op_valid = 1'b1;
                if (init_t_reg == INIT_LAST)
                begin
                    init_busy_next = 1'b0;
                end
                init_t_next = (cfg.wide_bus && init_t_reg == 3'd2) ? 3'd4
                                                                   : init_t_reg + 3'd1;
            end
        end
        else if (accept)
        begin
            op_valid = req_known;
            case (request.func)
                FN_INIT:
                begin
                    init_busy_next = 1'b1;
                    init_t_next    = 3'd1;
                    ctrl_next      = 3'd4;
                    entry_next     = 2'd2;
                end
                FN_CONTROL: ctrl_next = ctrl_upd;
                FN_ENTRY:   entry_next = entry_upd;
                default:    ctrl_next = ctrl_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_busy_reg <= 1'b0;
            init_t_reg    <= '0;
            ctrl_reg      <= '0;
            entry_reg     <= '0;
        end
        else
        begin
            init_busy_reg <= init_busy_next;
            init_t_reg    <= init_t_next;
            ctrl_reg      <= ctrl_next;
            entry_reg     <= entry_next;
        end
    end

endmodule

// ===== rtl/clcd_back.sv =====
module clcd_back
    import clcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fifo_empty,
    input  op_t  head,
    output logic fifo_pop,
    output logic empty,
    input  logic pop,
    output out_t result
);

    logic cur_valid_reg, cur_valid_next;
    op_t  cur_reg, cur_next;
    logic phase_reg, phase_next;
    logic out_valid_reg, out_valid_next;
    out_t out_reg;

    logic load, final_strobe, take;
    out_t strobe;

    assign load         = cur_valid_reg && (!out_valid_reg || pop);
    assign final_strobe = !cur_reg.split || phase_reg;
    assign take         = !cur_valid_reg || (load && final_strobe);
    assign fifo_pop     = take && !fifo_empty;

    // high nibble first on the narrow bus
    always_comb
    begin
        strobe.rs = cur_reg.rs;
        if (cur_reg.split && !phase_reg)
        begin
            strobe.bus_value = {4'h0, cur_reg.data[7:4]};
            strobe.lead_us   = '0;
            strobe.settle_us = settle_value(SET_100);
            strobe.last      = 1'b0;
        end
        else
        begin
            strobe.bus_value = cur_reg.split ? {4'h0, cur_reg.data[3:0]} : cur_reg.data;
            strobe.lead_us   = cur_reg.lead ? LEAD_POWER_ON : '0;
            strobe.settle_us = settle_value(cur_reg.settle);
            strobe.last      = cur_reg.last;
        end
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        phase_next     = phase_reg;
        if (take)
        begin
            cur_valid_next = !fifo_empty;
            cur_next       = head;
            phase_next     = 1'b0;
        end
        else if (load)
        begin
            phase_next = 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (load)
        begin
            out_reg <= strobe;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

// ===== rtl/char_lcd_parallel_controller.sv =====
// Character LCD controller for a 4-bit or 8-bit parallel bus. Each request
// (init, data, command, clear, home, cursor, CGRAM address, control flags,
// entry flags, shift) is accepted and turned into the ordered
// list of enable strobes the display must see; each strobe carries RS, the
// data-line value, a wait before it and a settle time after it, in
// microseconds, and last marks the final strobe of a request. The block
// does not time the waits itself. With pop held, results leave at one strobe
// per clock: a byte is one strobe on the 8-bit bus and two on the 4-bit
// bus (high nibble first, in bus_value bits 3..0); init is 7 strobes on
// the wide bus, 12 on the narrow, and after its accept cycle holds off new
// requests while its remaining 6 or 7 list steps enter the queue (longer
// when the queue is full). That one-strobe-per-cycle expander in front of
// the result register sets the sustained rate; a four-entry queue between
// the classifier and the expander absorbs bursts. Unknown request codes are
// accepted and produce nothing. Registers (write only while idle):
// 0x0 wide_bus, 0x4 columns, 0x8 rows_in_use, 0xC tall_font.
module char_lcd_parallel_controller
    import clcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        push,
    output logic        full,
    input  in_t         request,
    // strobe side
    output logic        empty,
    input  logic        pop,
    output out_t        result,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t cfg_reg;
    logic cfg_wr;

    logic fifo_full, fifo_empty, fifo_pop, op_valid;
    op_t  op_in, op_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // register file: only the low bits of each word are kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wide_bus    <= 1'b0;
            cfg_reg.columns     <= 6'd16;
            cfg_reg.rows_in_use <= 3'd2;
            cfg_reg.tall_font   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_WIDE_BUS:    cfg_reg.wide_bus    <= pwdata[0];
                REG_COLUMNS:     cfg_reg.columns     <= pwdata[5:0];
                REG_ROWS_IN_USE: cfg_reg.rows_in_use <= pwdata[2:0];
                REG_TALL_FONT:   cfg_reg.tall_font   <= pwdata[0];
                default:         cfg_reg.wide_bus    <= cfg_reg.wide_bus;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_WIDE_BUS:    prdata = {31'b0, cfg_reg.wide_bus};
            REG_COLUMNS:     prdata = {26'b0, cfg_reg.columns};
            REG_ROWS_IN_USE: prdata = {29'b0, cfg_reg.rows_in_use};
            REG_TALL_FONT:   prdata = {31'b0, cfg_reg.tall_font};
            default:         prdata = '0;
        endcase
    end

    // classifier: one queue entry per byte or raw init strobe
    clcd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .request   (request),
        .full      (full),
        .fifo_full (fifo_full),
        .op_valid  (op_valid),
        .op        (op_in)
    );

    clcd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (op_valid),
        .wr_op (op_in),
        .full  (fifo_full),
        .rd_en (fifo_pop),
        .rd_op (op_head),
        .empty (fifo_empty)
    );

    // expander: splits bytes into nibbles on the narrow bus, feeds the result register
    clcd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .head       (op_head),
        .fifo_pop   (fifo_pop),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

// ===== rtl/clcd_checker.sv =====
`include "char_lcd_parallel_controller_defines.svh"

module clcd_checker
    import clcd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic empty,
    input logic pop,
    input out_t result
);

    // only the first power-on strobe waits, and it is a command
    `CLCD_ASSERT_NOW(a_lead, !empty && result.lead_us != 16'd0, result.lead_us == LEAD_POWER_ON && !result.rs)

    // the long clear/home settle only follows a command strobe with no lead
    `CLCD_ASSERT_NOW(a_long_settle_cmd, !empty && result.settle_us == 13'd2100, result.lead_us == 16'd0 && !result.rs)

    // display data strobes carry no extra timing
    `CLCD_ASSERT_NOW(a_data_timing, !empty && result.rs, result.settle_us == 13'd100 && result.lead_us == 16'd0)

    // a waiting strobe is not dropped
    `CLCD_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result))

endmodule

bind char_lcd_parallel_controller clcd_checker u_clcd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb
    import clcd_pkg::*;
;

    // ------------------------------------------------------------------
    // Timing and pacing
    // ------------------------------------------------------------------
    localparam int HALF_PERIOD = 6;
    // An init request expands to at most 12 strobes behind a 4-entry queue.
    // The DRAIN_CYCLES pause after the last strobe covers a request that is
    // still in flight and makes no strobe (unknown code).
    localparam int DRAIN_CYCLES = 40;
    // Long receiver hold-off, so the request side backs up and stalls.
    localparam int HOLD_CYCLES = 150;
    // Slowest legal stretch with nothing accepted: the long hold-off plus
    // the drain pause and a register update. Taken several times over.
    localparam int STALL_LIMIT = 2000;

    // Request codes the block does not know; accepted, no strobes.
    localparam logic [3:0] FN_FIRST_UNUSED = 4'd10;
    localparam logic [3:0] FN_LAST_UNUSED  = 4'd15;

    // Settle times in microseconds.
    localparam logic [12:0] SETTLE_BASE  = 13'd100;
    localparam logic [12:0] INIT_LONG    = 13'd4500;
    localparam logic [12:0] INIT_SHORT   = 13'd150;
    localparam logic [12:0] CLEAR_EXTRA  = 13'd2000;

    // Power-on nibble values on the narrow bus.
    localparam logic [7:0] WAKE_NIBBLE   = 8'h03;
    localparam logic [7:0] NARROW_NIBBLE = 8'h02;

    // Flag bits of the display-control, entry-mode and shift commands.
    localparam logic [2:0] DISPLAY_ON    = 3'b100;
    localparam logic [1:0] LEFT_TO_RIGHT = 2'b10;
    localparam logic [7:0] SHIFT_RIGHT   = 8'h04;
    // Function-set option bits.
    localparam logic [7:0] FS_WIDE_BUS   = 8'h10;
    localparam logic [7:0] FS_TWO_LINES  = 8'h08;
    localparam logic [7:0] FS_TALL_FONT  = 8'h04;

    // ------------------------------------------------------------------
    // Strobe predictor and checker
    // ------------------------------------------------------------------
    class strobe_board;
        cfg_t       cfg;
        logic [2:0] ctrl_flags;
        logic [1:0] entry_flags;
        out_t       strobes_due[$];
        int         mismatches;

        function new();
            cfg.wide_bus    = 1'b0;
            cfg.columns     = 6'd16;
            cfg.rows_in_use = 3'd2;
            cfg.tall_font   = 1'b0;
            ctrl_flags  = '0;
            entry_flags = '0;
            mismatches  = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] v);
            case (idx)
                REG_WIDE_BUS:    cfg.wide_bus    = v[0];
                REG_COLUMNS:     cfg.columns     = v[5:0];
                REG_ROWS_IN_USE: cfg.rows_in_use = v[2:0];
                REG_TALL_FONT:   cfg.tall_font   = v[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return strobes_due.size();
        endfunction

        function void emit(logic rs, logic [7:0] bus, logic [15:0] lead,
                           logic [12:0] settle);
            out_t s;
            s.rs        = rs;
            s.bus_value = bus;
            s.lead_us   = lead;
            s.settle_us = settle;
            s.last      = 1'b0;
            strobes_due.push_back(s);
        endfunction

        // one byte: single strobe on the wide bus, high nibble first otherwise
        function void emit_byte(logic rs, logic [7:0] b, logic [12:0] extra);
            if (cfg.wide_bus)
                emit(rs, b, '0, SETTLE_BASE + extra);
            else
            begin
                emit(rs, {4'h0, b[7:4]}, '0, SETTLE_BASE);
                emit(rs, {4'h0, b[3:0]}, '0, SETTLE_BASE + extra);
            end
        endfunction

        function void note_request(in_t r);
            int         first;
            out_t       tail;
            logic [7:0] fn;
            logic [2:0] lim;
            logic [1:0] row;
            logic [7:0] off;
            logic [6:0] addr;
            logic [2:0] loc;

            first = strobes_due.size();
            case (r.func)
                FN_INIT:
                begin
                    fn = '0;
                    if (cfg.wide_bus) fn |= FS_WIDE_BUS;
                    if (cfg.rows_in_use > 3'd1) fn |= FS_TWO_LINES;
                    if (cfg.tall_font && cfg.rows_in_use == 3'd1) fn |= FS_TALL_FONT;
                    if (cfg.wide_bus)
                    begin
                        emit(1'b0, CMD_FUNCTION | fn, LEAD_POWER_ON, SETTLE_BASE + INIT_LONG);
                        emit(1'b0, CMD_FUNCTION | fn, '0, SETTLE_BASE + INIT_SHORT);
                        emit(1'b0, CMD_FUNCTION | fn, '0, SETTLE_BASE);
                    end
                    else
                    begin
                        emit(1'b0, WAKE_NIBBLE, LEAD_POWER_ON, SETTLE_BASE + INIT_LONG);
                        emit(1'b0, WAKE_NIBBLE, '0, SETTLE_BASE + INIT_LONG);
                        emit(1'b0, WAKE_NIBBLE, '0, SETTLE_BASE + INIT_SHORT);
                        emit(1'b0, NARROW_NIBBLE, '0, SETTLE_BASE);
                    end
                    emit_byte(1'b0, CMD_FUNCTION | fn, '0);
                    ctrl_flags = DISPLAY_ON;
                    emit_byte(1'b0, CMD_CONTROL | {5'b0, ctrl_flags}, '0);
                    emit_byte(1'b0, CMD_CLEAR, CLEAR_EXTRA);
                    entry_flags = LEFT_TO_RIGHT;
                    emit_byte(1'b0, CMD_ENTRY | {6'b0, entry_flags}, '0);
                end
                FN_DATA:    emit_byte(1'b1, r.value, '0);
                FN_COMMAND: emit_byte(1'b0, r.value, '0);
                FN_CLEAR:   emit_byte(1'b0, CMD_CLEAR, CLEAR_EXTRA);
                FN_HOME:    emit_byte(1'b0, CMD_HOME, CLEAR_EXTRA);
                FN_CURSOR:
                begin
                    // row clamped to rows in use; zero rows acts as one
                    lim = (cfg.rows_in_use == 3'd0) ? 3'd1 : cfg.rows_in_use;
                    row = r.row;
                    if ({1'b0, row} >= lim) row = 2'(lim - 3'd1);
                    case (row)
                        2'd0:    off = 8'h00;
                        2'd1:    off = {1'b0, ROW1_OFFSET};
                        2'd2:    off = {2'b0, cfg.columns};
                        default: off = {1'b0, ROW1_OFFSET} + {2'b0, cfg.columns};
                    endcase
                    addr = 7'({1'b0, r.col} + off);
                    emit_byte(1'b0, CMD_DDRAM | {1'b0, addr}, '0);
                end
                FN_CGRAM:
                begin
                    loc = (r.value > 8'd7) ? 3'd7 : r.value[2:0];
                    emit_byte(1'b0, CMD_CGRAM | {2'b0, loc, 3'b0}, '0);
                end
                FN_CONTROL:
                begin
                    if (r.value[7]) ctrl_flags |= r.value[2:0];
                    else            ctrl_flags &= ~r.value[2:0];
                    emit_byte(1'b0, CMD_CONTROL | {5'b0, ctrl_flags}, '0);
                end
                FN_ENTRY:
                begin
                    if (r.value[7]) entry_flags |= r.value[1:0];
                    else            entry_flags &= ~r.value[1:0];
                    emit_byte(1'b0, CMD_ENTRY | {6'b0, entry_flags}, '0);
                end
                FN_SHIFT:
                    emit_byte(1'b0, CMD_SHIFT | (r.value[0] ? SHIFT_RIGHT : 8'h00), '0);
                default: ;
            endcase
            if (strobes_due.size() > first)
            begin
                tail = strobes_due.pop_back();
                tail.last = 1'b1;
                strobes_due.push_back(tail);
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: strobe %s mismatch, expected %0h actual %0h",
                         $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_strobe(out_t got);
            out_t want;
            if (strobes_due.size() == 0)
            begin
                $display("%0t: strobe with none expected, expected nothing actual %p",
                         $time, got);
                mismatches++;
                return;
            end
            want = strobes_due.pop_front();
            compare_field("rs",        want.rs,        got.rs);
            compare_field("bus_value", want.bus_value, got.bus_value);
            compare_field("lead_us",   want.lead_us,   got.lead_us);
            compare_field("settle_us", want.settle_us, got.settle_us);
            compare_field("last",      want.last,      got.last);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    in_t         request;
    logic        empty;
    logic        pop;
    out_t        result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // calm: no idling on either side; hold_req: receiver holds off once
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    strobe_board board = new();

    char_lcd_parallel_controller DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Monitor: handshakes sampled at the edge, before any update lands.
    // Requests go to the predictor, strobes to the checker.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                board.note_request(request);
            if (pop && !empty)
                board.check_strobe(result);
        end
    end

    // Watchdog: consecutive cycles in which no request and no strobe moved.
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("char_lcd_parallel_controller verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Strobe side: random pop bursts, one long hold-off on request.
    // Each branch drives pop once and then waits on the clock.
    // ------------------------------------------------------------------
    initial
    begin
        pop <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Offer one request and hold it until full is low at an edge.
    task automatic send_request(in_t r);
        push    <= 1'b1;
        request <= r;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic pause_requests(int cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Send, then maybe leave a random gap.
    task automatic offer(in_t r);
        send_request(r);
        if (!calm && $urandom_range(0, 3) == 0)
            pause_requests($urandom_range(1, 13));
    endtask

    // Stop offering and wait until every predicted strobe is out, then
    // give a request that makes no strobe time to leave the block.
    task automatic drain();
        pause_requests(1);
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready, then
    // the port goes idle.
    task automatic write_register(logic [1:0] idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_register(idx, v);
        @(posedge clk);
    endtask

    // Mostly well-formed display traffic; a few unknown codes as noise.
    function automatic in_t random_request();
        in_t r;
        int  pick;
        r.value = 8'($urandom_range(0, 255));
        r.row   = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 7))
            0:       r.col = 7'd0;
            1:       r.col = 7'd127;
            default: r.col = 7'($urandom_range(0, 127));
        endcase
        pick = $urandom_range(0, 99);
        if      (pick < 5)  r.func = FN_INIT;
        else if (pick < 30) r.func = FN_DATA;
        else if (pick < 38) r.func = FN_COMMAND;
        else if (pick < 43) r.func = FN_CLEAR;
        else if (pick < 48) r.func = FN_HOME;
        else if (pick < 63) r.func = FN_CURSOR;
        else if (pick < 71) r.func = FN_CGRAM;
        else if (pick < 81) r.func = FN_CONTROL;
        else if (pick < 89) r.func = FN_ENTRY;
        else if (pick < 96) r.func = FN_SHIFT;
        else r.func = 4'($urandom_range(FN_FIRST_UNUSED, FN_LAST_UNUSED));
        return r;
    endfunction

    // One setting: idle block, all four registers, then an init request
    // followed by random traffic.
    task automatic run_phase(cfg_t c, int count, bit hold, bit quiet);
        in_t r;
        drain();
        write_register(REG_WIDE_BUS,    {31'b0, c.wide_bus});
        write_register(REG_COLUMNS,     {26'b0, c.columns});
        write_register(REG_ROWS_IN_USE, {29'b0, c.rows_in_use});
        write_register(REG_TALL_FONT,   {31'b0, c.tall_font});
        calm = quiet;
        hold_req = hold;
        r = random_request();
        r.func = FN_INIT;
        offer(r);
        repeat (count - 1) offer(random_request());
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n   <= 1'b0;
        push    <= 1'b0;
        request <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at the reset setting (narrow bus, 16 columns,
        // two rows): every code, field extremes, clamps and masks.
        offer('{FN_INIT,    8'h00, 7'd0,   2'd0});
        offer('{FN_DATA,    8'h00, 7'd0,   2'd0});
        offer('{FN_DATA,    8'hFF, 7'd127, 2'd3});
        offer('{FN_COMMAND, 8'hA5, 7'd0,   2'd0});
        offer('{FN_CLEAR,   8'h00, 7'd0,   2'd0});
        offer('{FN_HOME,    8'hFF, 7'd127, 2'd3});
        offer('{FN_CURSOR,  8'h00, 7'd0,   2'd0});
        // row beyond rows in use is clamped
        offer('{FN_CURSOR,  8'h00, 7'd5,   2'd3});
        // column plus row offset wraps past 127
        offer('{FN_CURSOR,  8'h00, 7'd127, 2'd1});
        offer('{FN_CGRAM,   8'h00, 7'd0,   2'd0});
        offer('{FN_CGRAM,   8'h07, 7'd0,   2'd0});
        // location above the last slot is clamped
        offer('{FN_CGRAM,   8'hFF, 7'd0,   2'd0});
        offer('{FN_CONTROL, 8'h87, 7'd0,   2'd0});
        offer('{FN_CONTROL, 8'h02, 7'd0,   2'd0});
        // mask bits above the flag width are ignored
        offer('{FN_CONTROL, 8'h78, 7'd0,   2'd0});
        offer('{FN_ENTRY,   8'h83, 7'd0,   2'd0});
        offer('{FN_ENTRY,   8'h01, 7'd0,   2'd0});
        offer('{FN_ENTRY,   8'hFC, 7'd0,   2'd0});
        offer('{FN_SHIFT,   8'h00, 7'd0,   2'd0});
        offer('{FN_SHIFT,   8'h01, 7'd0,   2'd0});
        // only bit 0 sets the direction
        offer('{FN_SHIFT,   8'hFE, 7'd0,   2'd0});
        // unknown codes: accepted, nothing out
        offer('{FN_FIRST_UNUSED, 8'h55, 7'd1, 2'd1});
        offer('{FN_LAST_UNUSED,  8'hAA, 7'd2, 2'd2});
        offer('{FN_DATA,    8'h5A, 7'd0,   2'd0});

        // Random phases across settings; the first one backs up the
        // request side with a long receiver hold-off, the last runs calm.
        run_phase('{1'b1, 6'd40, 3'd4, 1'b1}, 21, 1'b1, 1'b0);
        run_phase('{1'b0, 6'd1,  3'd1, 1'b1}, 21, 1'b0, 1'b0);
        run_phase('{1'b1, 6'd1,  3'd1, 1'b0}, 21, 1'b0, 1'b0);
        run_phase('{1'b0, 6'd40, 3'd3, 1'b0}, 21, 1'b0, 1'b0);
        run_phase('{1'b1, 6'd23, 3'd2, 1'b1}, 21, 1'b0, 1'b0);
        run_phase('{1'b0, 6'd40, 3'd4, 1'b1}, 21, 1'b0, 1'b1);

        drain();
        if (board.mismatches == 0)
            $display("char_lcd_parallel_controller verification clean");
        else
            $display("char_lcd_parallel_controller verification failed");
        $finish;
    end

endmodule
